// File: rtl/core/euler_zyx_vector_rotator_defines.svh
// Assertion macros used by the checker file.
`ifndef EULER_ZYX_VECTOR_ROTATOR_DEFINES_SVH
`define EULER_ZYX_VECTOR_ROTATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EULR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define EULR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: rtl/core/eulr_pkg.sv
`timescale 1ns / 1ps
package eulr_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COEF_WIDTH      = 32;
  localparam int COEF_FRAC       = 30;
  localparam int NUM_CFG         = 6;
  localparam int CFG_IDX_WIDTH   = 3;
  localparam int OP_WIDTH        = 3;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE  = COEF_WIDTH'(1) << COEF_FRAC;
  localparam logic signed [COEF_WIDTH-1:0] COEF_ZERO = '0;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ROT_X = 3'd0,
    OP_ROT_Y = 3'd1,
    OP_ROT_Z = 3'd2,
    OP_ZX    = 3'd3,
    OP_ZYX   = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_Z = 3'd4,
    REG_SIN_Z = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] cos_x;
    logic signed [COEF_WIDTH-1:0] sin_x;
    logic signed [COEF_WIDTH-1:0] cos_y;
    logic signed [COEF_WIDTH-1:0] sin_y;
    logic signed [COEF_WIDTH-1:0] cos_z;
    logic signed [COEF_WIDTH-1:0] sin_z;
  } coef_t;

  typedef struct packed {
    logic [OP_WIDTH-1:0] op;
    logic                sat;
    logic                last;
  } meta_t;

  function automatic logic axis_active(axis_e axis, logic [OP_WIDTH-1:0] op);
    logic act;
    act = 1'b0;
    case (axis)
      AXIS_X:  act = (op inside {OP_ROT_X, OP_ZX, OP_ZYX});
      AXIS_Y:  act = (op inside {OP_ROT_Y, OP_ZYX});
      AXIS_Z:  act = (op inside {OP_ROT_Z, OP_ZX, OP_ZYX});
      default: act = 1'b0;
    endcase
    return act;
  endfunction

endpackage

// File: rtl/core/eulr_ifs.sv
`timescale 1ns / 1ps
interface eulr_in_if import eulr_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic [OP_WIDTH-1:0] operation;
  logic signed [CW-1:0] in_x;
  logic signed [CW-1:0] in_y;
  logic signed [CW-1:0] in_z;
  logic                last_in_set;

  modport source (output valid, operation, in_x, in_y, in_z, last_in_set, input ready);
  modport sink   (input valid, operation, in_x, in_y, in_z, last_in_set, output ready);
endinterface

interface eulr_out_if import eulr_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic                 saturated;
  logic                 last_out;

  modport source (output valid, out_x, out_y, out_z, saturated, last_out, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, last_out, output ready);
endinterface

interface eulr_cfg_if import eulr_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_WIDTH-1:0] index;
  logic [COEF_WIDTH-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/eulr_cfg.sv
`timescale 1ns / 1ps
module eulr_cfg import eulr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  eulr_cfg_if.sink   cfg,
  output coef_t      coef_o
);

  coef_t coef_d, coef_q;

  assign cfg.ready = 1'b1;

  always_comb begin
    coef_d = coef_q;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_COS_X: coef_d.cos_x = cfg.data;
        REG_SIN_X: coef_d.sin_x = cfg.data;
        REG_COS_Y: coef_d.cos_y = cfg.data;
        REG_SIN_Y: coef_d.sin_y = cfg.data;
        REG_COS_Z: coef_d.cos_z = cfg.data;
        REG_SIN_Z: coef_d.sin_z = cfg.data;
        default:   coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{cos_x: COEF_ONE, sin_x: COEF_ZERO,
                  cos_y: COEF_ONE, sin_y: COEF_ZERO,
                  cos_z: COEF_ONE, sin_z: COEF_ZERO};
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// File: rtl/core/eulr_rot_stage.sv
`timescale 1ns / 1ps
module eulr_rot_stage import eulr_pkg::*; #(
  parameter int    CW   = COORD_WIDTH_DEF,
  parameter axis_e AXIS = AXIS_Z
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [COEF_WIDTH-1:0] cos_i,
  input  logic signed [COEF_WIDTH-1:0] sin_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [CW-1:0]         a_i,
  input  logic signed [CW-1:0]         b_i,
  input  logic signed [CW-1:0]         p_i,
  input  meta_t                        meta_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [CW-1:0]         a_o,
  output logic signed [CW-1:0]         b_o,
  output logic signed [CW-1:0]         p_o,
  output meta_t                        meta_o
);

  localparam int PW = CW + COEF_WIDTH;
  localparam int SW = PW + 1;
  localparam int RW = SW - COEF_FRAC;
  localparam logic signed [SW-1:0] Rnd =
    {{(SW-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
  localparam logic signed [CW-1:0] MaxVal = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MinVal = {1'b1, {(CW-1){1'b0}}};

  // product stage
  logic                 v1_q;
  logic                 ready1;
  logic signed [PW-1:0] pca_d, psb_d, psa_d, pcb_d;
  logic signed [PW-1:0] pca_q, psb_q, psa_q, pcb_q;
  logic signed [CW-1:0] a1_q, b1_q, p1_q;
  meta_t                meta1_q;
  logic                 en1_q;

  // sum, round and clip stage
  logic                 v2_q;
  logic                 ready2;
  logic signed [SW-1:0] sum_a, sum_b;
  logic signed [RW-1:0] res_a, res_b;
  logic                 ovf_a, ovf_b;
  logic signed [CW-1:0] a2_d, b2_d, a2_q, b2_q, p2_q;
  meta_t                meta2_d, meta2_q;

  assign ready2  = !v2_q || ready_i;
  assign ready1  = !v1_q || ready2;
  assign ready_o = ready1;

  assign pca_d = cos_i * a_i;
  assign psb_d = sin_i * b_i;
  assign psa_d = sin_i * a_i;
  assign pcb_d = cos_i * b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && valid_i) begin
      pca_q   <= pca_d;
      psb_q   <= psb_d;
      psa_q   <= psa_d;
      pcb_q   <= pcb_d;
      a1_q    <= a_i;
      b1_q    <= b_i;
      p1_q    <= p_i;
      meta1_q <= meta_i;
      en1_q   <= axis_active(AXIS, meta_i.op);
    end
  end

  assign sum_a = SW'(pca_q) - SW'(psb_q) + Rnd;
  assign sum_b = SW'(psa_q) + SW'(pcb_q) + Rnd;
  assign res_a = sum_a[SW-1:COEF_FRAC];
  assign res_b = sum_b[SW-1:COEF_FRAC];
  assign ovf_a = (res_a[RW-1:CW-1] != {(RW-CW+1){res_a[RW-1]}});
  assign ovf_b = (res_b[RW-1:CW-1] != {(RW-CW+1){res_b[RW-1]}});

  always_comb begin
    meta2_d = meta1_q;
    a2_d    = a1_q;
    b2_d    = b1_q;
    if (en1_q) begin
      a2_d        = ovf_a ? (res_a[RW-1] ? MinVal : MaxVal) : res_a[CW-1:0];
      b2_d        = ovf_b ? (res_b[RW-1] ? MinVal : MaxVal) : res_b[CW-1:0];
      meta2_d.sat = meta1_q.sat | ovf_a | ovf_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && v1_q) begin
      a2_q    <= a2_d;
      b2_q    <= b2_d;
      p2_q    <= p1_q;
      meta2_q <= meta2_d;
    end
  end

  assign valid_o = v2_q;
  assign a_o     = a2_q;
  assign b_o     = b2_q;
  assign p_o     = p2_q;
  assign meta_o  = meta2_q;

endmodule

// File: rtl/core/euler_zyx_vector_rotator.sv
`timescale 1ns / 1ps
// Pipeline: two registers per axis, Z, Y, X, from item acceptance to result.
// Throughput: one item per cycle while the output is not stalled; each axis unit holds
// four products in a register.
// Ready: propagates back through the stage valid bits, so empty stages fill under a stall.
// Reset: clears all stage valid bits; coefficients return to identity (cos 1.0, sin 0.0).
module euler_zyx_vector_rotator import eulr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  eulr_cfg_if.sink    cfg_i,
  eulr_in_if.sink     in_i,
  eulr_out_if.source  out_o
);

  coef_t coef;

  logic                          vz, vy, vx;
  logic                          rdy_z, rdy_y, rdy_x;
  logic signed [COORD_WIDTH-1:0] z_a, z_b, z_p;
  logic signed [COORD_WIDTH-1:0] y_a, y_b, y_p;
  logic signed [COORD_WIDTH-1:0] x_a, x_b, x_p;
  meta_t                         meta_in, meta_z, meta_y, meta_x;

  eulr_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .coef_o (coef)
  );

  assign meta_in = '{op: in_i.operation, sat: 1'b0, last: in_i.last_in_set};
  assign in_i.ready = rdy_z;

  // z axis: pair (x, y)
  eulr_rot_stage #(.CW(COORD_WIDTH), .AXIS(AXIS_Z)) u_rot_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cos_i   (coef.cos_z),
    .sin_i   (coef.sin_z),
    .valid_i (in_i.valid),
    .ready_o (rdy_z),
    .a_i     (in_i.in_x),
    .b_i     (in_i.in_y),
    .p_i     (in_i.in_z),
    .meta_i  (meta_in),
    .valid_o (vz),
    .ready_i (rdy_y),
    .a_o     (z_a),
    .b_o     (z_b),
    .p_o     (z_p),
    .meta_o  (meta_z)
  );

  // y axis: pair (z, x)
  eulr_rot_stage #(.CW(COORD_WIDTH), .AXIS(AXIS_Y)) u_rot_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cos_i   (coef.cos_y),
    .sin_i   (coef.sin_y),
    .valid_i (vz),
    .ready_o (rdy_y),
    .a_i     (z_p),
    .b_i     (z_a),
    .p_i     (z_b),
    .meta_i  (meta_z),
    .valid_o (vy),
    .ready_i (rdy_x),
    .a_o     (y_a),
    .b_o     (y_b),
    .p_o     (y_p),
    .meta_o  (meta_y)
  );

  // x axis: pair (y, z)
  eulr_rot_stage #(.CW(COORD_WIDTH), .AXIS(AXIS_X)) u_rot_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cos_i   (coef.cos_x),
    .sin_i   (coef.sin_x),
    .valid_i (vy),
    .ready_o (rdy_x),
    .a_i     (y_p),
    .b_i     (y_a),
    .p_i     (y_b),
    .meta_i  (meta_y),
    .valid_o (vx),
    .ready_i (out_o.ready),
    .a_o     (x_a),
    .b_o     (x_b),
    .p_o     (x_p),
    .meta_o  (meta_x)
  );

  assign out_o.valid     = vx;
  assign out_o.out_x     = x_p;
  assign out_o.out_y     = x_a;
  assign out_o.out_z     = x_b;
  assign out_o.saturated = meta_x.sat;
  assign out_o.last_out  = meta_x.last;

endmodule

// File: rtl/core/eulr_checker.sv
`timescale 1ns / 1ps
`include "euler_zyx_vector_rotator_defines.svh"
module eulr_checker import eulr_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          cfg_ready,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [CW-1:0] out_x,
  input logic [CW-1:0] out_y,
  input logic [CW-1:0] out_z,
  input logic          saturated,
  input logic          last_out
);

  `EULR_ASSERT_IMPL(cfg_always_ready, clk_i, rst_ni, 1'b1, cfg_ready)
  `EULR_ASSERT_IMPL(stall_only_from_out, clk_i, rst_ni, !in_ready, out_valid && !out_ready)
  `EULR_ASSERT_NEXT(out_valid_held, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `EULR_ASSERT_NEXT(out_item_held, clk_i, rst_ni, out_valid && !out_ready, $stable({out_x, out_y, out_z, saturated, last_out}))

endmodule

bind euler_zyx_vector_rotator eulr_checker #(.CW(COORD_WIDTH)) u_eulr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .cfg_ready (cfg_i.ready),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_x     (out_o.out_x),
  .out_y     (out_o.out_y),
  .out_z     (out_o.out_z),
  .saturated (out_o.saturated),
  .last_out  (out_o.last_out)
);

// File: tb/euler_zyx_vector_rotator_tb.sv
`timescale 1ns / 1ps
module euler_zyx_vector_rotator_tb;
  import eulr_pkg::*;

  localparam int CW            = COORD_WIDTH_DEF;
  localparam int PIPE_TAIL     = 12;
  localparam int NUM_SEGMENTS  = 8;
  localparam int SEGMENT_ITEMS = 100;
  localparam int DIR_ROWS      = 24;
  localparam int NUM_SETS      = 5;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  localparam logic signed [COEF_WIDTH-1:0] COEF_HALF = COEF_ONE >>> 1;
  localparam logic signed [COEF_WIDTH-1:0] COEF_MAX  = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0] COEF_MIN  = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  localparam logic [OP_WIDTH-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_WIDTH-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_WIDTH-1:0] OP_SPARE_7 = 3'd7;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_WIDTH-1:0] op;
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic                last;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
    logic   last;
  } result_t;

  typedef struct packed {
    coord_t v;
    logic   clip;
  } row_out_t;

  typedef struct {
    int unsigned set;
    point_t      pt;
    logic        known;
    result_t     want;
  } dir_row_t;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic out_ready = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          points_sent    = 0;
  int          results_seen   = 0;
  int          sat_seen       = 0;
  int          settings_count = 0;

  coef_t    rot_coefs;
  result_t  rotated_q[$];
  dir_row_t dir_tab[DIR_ROWS];
  coef_t    coef_sets[NUM_SETS];

  eulr_cfg_if           cfg_bus ();
  eulr_in_if  #(.CW(CW)) in_bus  ();
  eulr_out_if #(.CW(CW)) out_bus ();

  assign out_bus.ready = out_ready;

  euler_zyx_vector_rotator #(.COORD_WIDTH(CW)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [COEF_WIDTH+1:0] widen(input logic signed [COEF_WIDTH-1:0] c);
    return (COEF_WIDTH+2)'(c);
  endfunction

  // round half up, then clip to the coordinate range
  function automatic row_out_t fix_row(input logic signed [COEF_WIDTH+1:0] k1, input coord_t a,
                                       input logic signed [COEF_WIDTH+1:0] k2, input coord_t b);
    logic signed [67:0] acc;
    row_out_t           r;
    acc = 68'(k1) * 68'(a) + 68'(k2) * 68'(b) + (68'sd1 <<< (COEF_FRAC - 1));
    acc = acc >>> COEF_FRAC;
    r.clip = 1'b0;
    if (acc > 68'(COORD_MAX)) begin
      r.v    = COORD_MAX;
      r.clip = 1'b1;
    end else if (acc < 68'(COORD_MIN)) begin
      r.v    = COORD_MIN;
      r.clip = 1'b1;
    end else begin
      r.v = acc[CW-1:0];
    end
    return r;
  endfunction

  function automatic result_t rotate_point(input point_t p);
    coord_t   x, y, z;
    logic     clip;
    row_out_t r0, r1;
    result_t  res;
    x    = p.x;
    y    = p.y;
    z    = p.z;
    clip = 1'b0;
    if (p.op inside {OP_ROT_Z, OP_ZX, OP_ZYX}) begin
      r0 = fix_row(widen(rot_coefs.cos_z), x, -widen(rot_coefs.sin_z), y);
      r1 = fix_row(widen(rot_coefs.sin_z), x, widen(rot_coefs.cos_z), y);
      x = r0.v;
      y = r1.v;
      clip |= r0.clip | r1.clip;
    end
    if (p.op inside {OP_ROT_Y, OP_ZYX}) begin
      r0 = fix_row(widen(rot_coefs.cos_y), x, widen(rot_coefs.sin_y), z);
      r1 = fix_row(-widen(rot_coefs.sin_y), x, widen(rot_coefs.cos_y), z);
      x = r0.v;
      z = r1.v;
      clip |= r0.clip | r1.clip;
    end
    if (p.op inside {OP_ROT_X, OP_ZX, OP_ZYX}) begin
      r0 = fix_row(widen(rot_coefs.cos_x), y, -widen(rot_coefs.sin_x), z);
      r1 = fix_row(widen(rot_coefs.sin_x), y, widen(rot_coefs.cos_x), z);
      y = r0.v;
      z = r1.v;
      clip |= r0.clip | r1.clip;
    end
    res.x    = x;
    res.y    = y;
    res.z    = z;
    res.sat  = clip;
    res.last = p.last;
    return res;
  endfunction

  function automatic logic signed [COEF_WIDTH-1:0] rand_coef();
    logic signed [COEF_WIDTH-1:0] c;
    case ($urandom_range(9))
      0:       c = COEF_ONE;
      1:       c = -COEF_ONE;
      2:       c = COEF_ZERO;
      3:       c = COEF_MAX;
      4:       c = COEF_MIN;
      5:       c = $urandom();
      default: c = $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
    endcase
    return c;
  endfunction

  function automatic coord_t rand_coord();
    coord_t v;
    case ($urandom_range(7))
      0:       v = COORD_MAX;
      1:       v = COORD_MIN;
      2:       v = $urandom_range(32'h0002_0000, 0) - 32'h0001_0000;
      3:       v = $urandom_range(32'h0200_0000, 0) - 32'h0100_0000;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic point_t rand_point();
    point_t p;
    if ($urandom_range(9) == 0) p.op = OP_WIDTH'($urandom_range(OP_SPARE_7, OP_SPARE_5));
    else p.op = OP_WIDTH'($urandom_range(OP_ZYX, OP_ROT_X));
    p.x    = rand_coord();
    p.y    = rand_coord();
    p.z    = rand_coord();
    p.last = 1'($urandom_range(1));
    return p;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t result %0d: %s", $time, results_seen, what);
    mismatch_count++;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (rotated_q.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing pending", got));
      return;
    end
    want = rotated_q.pop_front();
    results_seen++;
    if (got.sat) sat_seen++;
    if (got.x !== want.x) report_mismatch($sformatf("out_x %h, want %h", got.x, want.x));
    if (got.y !== want.y) report_mismatch($sformatf("out_y %h, want %h", got.y, want.y));
    if (got.z !== want.z) report_mismatch($sformatf("out_z %h, want %h", got.z, want.z));
    if (got.sat !== want.sat) report_mismatch($sformatf("saturated %b, want %b", got.sat, want.sat));
    if (got.last !== want.last) report_mismatch($sformatf("last_out %b, want %b", got.last, want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_ready)
      check_result({out_bus.out_x, out_bus.out_y, out_bus.out_z, out_bus.saturated, out_bus.last_out});
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_point(input point_t p, input result_t want);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.operation   <= p.op;
    in_bus.in_x        <= p.x;
    in_bus.in_y        <= p.y;
    in_bus.in_z        <= p.z;
    in_bus.last_in_set <= p.last;
    do @(posedge clk_i); while (!in_bus.ready);
    rotated_q.push_back(want);
    points_sent++;
  endtask

  // hold the sender until every pending result is out
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (rotated_q.size() != 0);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [COEF_WIDTH-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      REG_COS_X: rot_coefs.cos_x = val;
      REG_SIN_X: rot_coefs.sin_x = val;
      REG_COS_Y: rot_coefs.cos_y = val;
      REG_SIN_Y: rot_coefs.sin_y = val;
      REG_COS_Z: rot_coefs.cos_z = val;
      REG_SIN_Z: rot_coefs.sin_z = val;
      default: ;
    endcase
  endtask

  task automatic program_coefs(input coef_t c);
    cfg_put(REG_COS_X, c.cos_x);
    cfg_put(REG_SPARE_6, $urandom());
    cfg_put(REG_SIN_X, c.sin_x);
    cfg_put(REG_COS_Y, c.cos_y);
    cfg_put(REG_SIN_Y, c.sin_y);
    cfg_put(REG_SPARE_7, $urandom());
    cfg_put(REG_COS_Z, c.cos_z);
    cfg_put(REG_SIN_Z, c.sin_z);
    cfg_bus.valid <= 1'b0;
    settings_count++;
  endtask

  initial begin
    coef_t       cs;
    point_t      pt;
    int unsigned cur_set;

    in_bus.valid       <= 1'b0;
    in_bus.operation   <= OP_ROT_X;
    in_bus.in_x        <= '0;
    in_bus.in_y        <= '0;
    in_bus.in_z        <= '0;
    in_bus.last_in_set <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= REG_COS_X;
    cfg_bus.data       <= '0;

    coef_sets = '{
      '{COEF_ONE,  COEF_ZERO,  COEF_ONE,  COEF_ZERO,  COEF_ONE,  COEF_ZERO},
      '{-COEF_ONE, COEF_ZERO,  -COEF_ONE, COEF_ZERO,  -COEF_ONE, COEF_ZERO},
      '{COEF_ZERO, COEF_ONE,   COEF_ZERO, COEF_ONE,   COEF_ZERO, COEF_ONE},
      '{COEF_MAX,  COEF_MIN,   COEF_MAX,  COEF_MIN,   COEF_MAX,  COEF_MIN},
      '{COEF_HALF, -COEF_HALF, COEF_HALF, -COEF_HALF, COEF_HALF, -COEF_HALF}
    };

    dir_tab = '{
      '{0, '{OP_ROT_X, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0}, 1'b1,
           '{COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b0}},
      '{0, '{OP_ROT_Y, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1}, 1'b1,
           '{COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 1'b1}},
      '{0, '{OP_ROT_Z, COORD_MAX, COORD_MAX, COORD_MIN, 1'b0}, 1'b1,
           '{COORD_MAX, COORD_MAX, COORD_MIN, 1'b0, 1'b0}},
      '{0, '{OP_ZX, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1}, 1'b1,
           '{COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b1}},
      '{0, '{OP_ZYX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0}, 1'b1,
           '{COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0}},
      '{0, '{OP_ZYX, 0, 0, 0, 1'b1}, 1'b1, '{0, 0, 0, 1'b0, 1'b1}},
      '{0, '{OP_SPARE_6, 32'sh1234_5678, -1, 1, 1'b0}, 1'b1,
           '{32'sh1234_5678, -1, 1, 1'b0, 1'b0}},
      '{0, '{OP_SPARE_7, COORD_MIN, COORD_MAX, -65536, 1'b1}, 1'b1,
           '{COORD_MIN, COORD_MAX, -65536, 1'b0, 1'b1}},
      '{1, '{OP_ROT_X, 5, COORD_MIN, 65536, 1'b0}, 1'b1, '{5, COORD_MAX, -65536, 1'b1, 1'b0}},
      '{1, '{OP_ROT_Y, COORD_MAX, 7, COORD_MIN, 1'b1}, 1'b1,
           '{COORD_MIN + 1, 7, COORD_MAX, 1'b1, 1'b1}},
      '{1, '{OP_ROT_Z, COORD_MIN, COORD_MIN, 3, 1'b0}, 1'b1,
           '{COORD_MAX, COORD_MAX, 3, 1'b1, 1'b0}},
      '{1, '{OP_ZX, 1, 2, 3, 1'b1}, 1'b1, '{-1, 2, -3, 1'b0, 1'b1}},
      '{1, '{OP_ZYX, COORD_MAX, 0, 0, 1'b0}, 1'b1, '{COORD_MAX, 0, 0, 1'b0, 1'b0}},
      '{1, '{OP_SPARE_5, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1}, 1'b1,
           '{COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b1}},
      '{2, '{OP_ROT_X, 1, 2, 3, 1'b0}, 1'b0, '0},
      '{2, '{OP_ROT_Y, COORD_MIN, 0, COORD_MAX, 1'b1}, 1'b0, '0},
      '{2, '{OP_ROT_Z, COORD_MIN, COORD_MAX, 0, 1'b0}, 1'b0, '0},
      '{2, '{OP_ZYX, 32'sh0001_2345, -77777, 32'sh7000_0000, 1'b1}, 1'b0, '0},
      '{3, '{OP_ROT_X, 0, COORD_MAX, COORD_MIN, 1'b0}, 1'b0, '0},
      '{3, '{OP_ZYX, COORD_MIN, COORD_MAX, 1, 1'b1}, 1'b0, '0},
      '{3, '{OP_ZX, -1, 1, -1, 1'b0}, 1'b0, '0},
      '{3, '{OP_ROT_Y, 65535, -65535, 1, 1'b1}, 1'b0, '0},
      '{4, '{OP_ROT_Z, 1, 0, 0, 1'b0}, 1'b0, '0},
      '{4, '{OP_ROT_X, 0, -1, 3, 1'b1}, 1'b0, '0}
    };

    rot_coefs = coef_sets[0];
    cur_set   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set != cur_set) begin
        settle();
        program_coefs(coef_sets[dir_tab[i].set]);
        cur_set = dir_tab[i].set;
      end
      pt = dir_tab[i].pt;
      push_point(pt, dir_tab[i].known ? dir_tab[i].want : rotate_point(pt));
    end

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      settle();
      case (seg % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
        end
      endcase
      cs = '{rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      program_coefs(cs);
      repeat (SEGMENT_ITEMS) begin
        pt = rand_point();
        push_point(pt, rotate_point(pt));
      end
    end

    settle();
    repeat (PIPE_TAIL) @(posedge clk_i);

    $display("Covered %0d points (%0d directed), %0d results checked, %0d with clipping",
             points_sent, DIR_ROWS, results_seen, sat_seen);
    $display("Covered %0d coefficient settings under free-running, sender-gap, receiver-stall"
             , settings_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Timeout: rotator stopped making progress");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
